[rtl/tomq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tomq_pkg;
  localparam int OBJ_BITS = 16;
  localparam int MSG_BITS = 16;
  localparam int OUTL_BITS = 8;
  localparam int OCC_BITS = 7;
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;
endpackage
`default_nettype wire

[rtl/tomq_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module tomq_front #(
  parameter int STAMP_BITS = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           action,
  input  wire logic [STAMP_BITS-1:0]          stamp,
  input  wire logic [tomq_pkg::OBJ_BITS-1:0]  target_object,
  input  wire logic [tomq_pkg::MSG_BITS-1:0]  message_handle,
  input  wire logic [tomq_pkg::OUTL_BITS-1:0] outlet_number,
  output logic                                cmd_valid,
  input  wire logic                           cmd_ready,
  output logic                                cmd_action,
  output logic [STAMP_BITS-1:0]               cmd_stamp,
  output logic [tomq_pkg::OBJ_BITS-1:0]       cmd_object,
  output logic [tomq_pkg::MSG_BITS-1:0]       cmd_message,
  output logic [tomq_pkg::OUTL_BITS-1:0]      cmd_outlet
);
  // single-entry command buffer
  assign in_ready = !cmd_valid || cmd_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd_action  <= action;
      cmd_stamp   <= stamp;
      cmd_object  <= target_object;
      cmd_message <= message_handle;
      cmd_outlet  <= outlet_number;
    end
  end
endmodule
`default_nettype wire

[rtl/tomq_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module tomq_back #(
  parameter int CAPACITY   = 64,
  parameter int STAMP_BITS = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  output logic                                cmd_ready,
  input  wire logic                           cmd_action,
  input  wire logic [STAMP_BITS-1:0]          cmd_stamp,
  input  wire logic [tomq_pkg::OBJ_BITS-1:0]  cmd_object,
  input  wire logic [tomq_pkg::MSG_BITS-1:0]  cmd_message,
  input  wire logic [tomq_pkg::OUTL_BITS-1:0] cmd_outlet,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [1:0]                          status,
  output logic [tomq_pkg::OCC_BITS-1:0]       occupancy,
  output logic                                front_valid,
  output logic [STAMP_BITS-1:0]               front_stamp,
  output logic [tomq_pkg::OBJ_BITS-1:0]       front_object,
  output logic [tomq_pkg::MSG_BITS-1:0]       front_message,
  output logic [tomq_pkg::OUTL_BITS-1:0]      front_outlet
);
  localparam int CW = $clog2(CAPACITY + 1);

  // shift-register sorted store, each cell decides locally
  logic [STAMP_BITS-1:0]          s_stamp [CAPACITY];
  logic [tomq_pkg::OBJ_BITS-1:0]  s_obj   [CAPACITY];
  logic [tomq_pkg::MSG_BITS-1:0]  s_msg   [CAPACITY];
  logic [tomq_pkg::OUTL_BITS-1:0] s_outl  [CAPACITY];
  logic [CW-1:0]                  count;
  logic [CAPACITY-1:0]            later;
  logic [CAPACITY-1:0]            hit;
  logic [CAPACITY-1:0]            hit_before;
  logic [CAPACITY-1:0]            later_reg;
  logic [CAPACITY-1:0]            before_reg;
  logic                           any_hit;
  logic                           phase;
  logic                           full_q;
  logic                           do_ins;
  logic                           do_rem;
  logic [CW-1:0]                  count_next;
  logic [1:0]                     st_next;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      later[i] = (CW'(i) < count) && (cmd_stamp < s_stamp[i]);
      hit[i] = (CW'(i) < count) && s_obj[i] == cmd_object &&
               s_msg[i] == cmd_message && s_outl[i] == cmd_outlet;
    end
  end

  // prefix of hits done as a registered step: hit_before[i] = any hit at or below i
  always_comb begin
    hit_before[0] = hit[0];
    for (int i = 1; i < CAPACITY; i++) begin
      hit_before[i] = hit_before[i-1] | hit[i];
    end
  end

  assign full_q = (count >= CW'(CAPACITY));
  assign any_hit = before_reg[CAPACITY-1];
  assign cmd_ready = phase && empty;
  assign do_ins = cmd_ready && cmd_valid && cmd_action == tomq_pkg::ACT_INSERT && !full_q;
  assign do_rem = cmd_ready && cmd_valid && cmd_action == tomq_pkg::ACT_REMOVE && any_hit;

  always_comb begin
    count_next = count;
    st_next = tomq_pkg::ST_DONE;
    if (cmd_action == tomq_pkg::ACT_INSERT) begin
      if (full_q) st_next = tomq_pkg::ST_FULL;
      else count_next = count + CW'(1);
    end else begin
      if (!any_hit) st_next = tomq_pkg::ST_MISS;
      else count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      count <= '0;
      empty <= 1'b1;
    end else begin
      if (!empty && pop) empty <= 1'b1;
      if (cmd_ready && cmd_valid) begin
        phase <= 1'b0;
        count <= count_next;
        empty <= 1'b0;
      end else if (cmd_valid && !phase) begin
        phase <= 1'b1;
      end
    end
    if (cmd_valid && !phase) begin
      later_reg  <= later;
      before_reg <= hit_before;
    end
    if (do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (later_reg[i]) begin
          if (i + 1 < CAPACITY) begin
            s_stamp[(i+1)%CAPACITY] <= s_stamp[i];
            s_obj[(i+1)%CAPACITY]   <= s_obj[i];
            s_msg[(i+1)%CAPACITY]   <= s_msg[i];
            s_outl[(i+1)%CAPACITY]  <= s_outl[i];
          end
        end
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if ((CW'(i) == count && !later_reg[i] &&
             (i == 0 || !later_reg[(i+CAPACITY-1)%CAPACITY]) && later_reg == '0) ||
            (later_reg[i] && (i == 0 || !later_reg[(i+CAPACITY-1)%CAPACITY]))) begin
          s_stamp[i] <= cmd_stamp;
          s_obj[i]   <= cmd_object;
          s_msg[i]   <= cmd_message;
          s_outl[i]  <= cmd_outlet;
        end
      end
    end
    if (do_rem) begin
      for (int i = 0; i + 1 < CAPACITY; i++) begin
        if (before_reg[i]) begin
          s_stamp[i] <= s_stamp[i+1];
          s_obj[i]   <= s_obj[i+1];
          s_msg[i]   <= s_msg[i+1];
          s_outl[i]  <= s_outl[i+1];
        end
      end
    end
    if (cmd_ready && cmd_valid) begin
      status    <= st_next;
      occupancy <= tomq_pkg::OCC_BITS'(count_next);
    end
  end

  // front is hidden in the cycle after a command is accepted, while front_upd is set
  logic front_upd;
  always_ff @(posedge clk) begin
    if (rst) front_upd <= 1'b0;
    else front_upd <= cmd_ready && cmd_valid;
  end
  logic show;
  assign show = !front_upd;
  assign front_valid   = show && count != '0;
  assign front_stamp   = front_valid ? s_stamp[0] : '0;
  assign front_object  = front_valid ? s_obj[0] : '0;
  assign front_message = front_valid ? s_msg[0] : '0;
  assign front_outlet  = front_valid ? s_outl[0] : '0;
endmodule
`default_nettype wire

[rtl/timestamp_ordered_message_queue_top.sv]
// Sorted message queue of CAPACITY entries held in a shift-register store.
// In the back end each item is first compared against every cell, with the
// compare result registered, and then the store is shifted; the result is
// offered after the hold register has followed it. The back end takes its next
// item only in the cycle after the previous result has been popped, so a late
// pop stalls it. A one-entry command buffer in front takes the next item
// meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module timestamp_ordered_message_queue_top #(
  parameter int CAPACITY   = 64,
  parameter int STAMP_BITS = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           action,
  input  wire logic [STAMP_BITS-1:0]          stamp,
  input  wire logic [tomq_pkg::OBJ_BITS-1:0]  target_object,
  input  wire logic [tomq_pkg::MSG_BITS-1:0]  message_handle,
  input  wire logic [tomq_pkg::OUTL_BITS-1:0] outlet_number,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [1:0]                          status,
  output logic [tomq_pkg::OCC_BITS-1:0]       occupancy,
  output logic                                front_valid,
  output logic [STAMP_BITS-1:0]               front_stamp,
  output logic [tomq_pkg::OBJ_BITS-1:0]       front_object,
  output logic [tomq_pkg::MSG_BITS-1:0]       front_message,
  output logic [tomq_pkg::OUTL_BITS-1:0]      front_outlet
);
  logic in_ready, cmd_valid, cmd_ready, cmd_action, empty_raw, fv;
  logic [STAMP_BITS-1:0] cmd_stamp, fs;
  logic [tomq_pkg::OBJ_BITS-1:0] cmd_object, fo;
  logic [tomq_pkg::MSG_BITS-1:0] cmd_message, fm;
  logic [tomq_pkg::OUTL_BITS-1:0] cmd_outlet, fl;
  logic hold;

  assign full = !in_ready;

  tomq_front #(.STAMP_BITS(STAMP_BITS)) u_front (
    .clk, .rst, .in_valid(push), .in_ready, .action, .stamp, .target_object,
    .message_handle, .outlet_number, .cmd_valid, .cmd_ready, .cmd_action,
    .cmd_stamp, .cmd_object, .cmd_message, .cmd_outlet
  );

  tomq_back #(.CAPACITY(CAPACITY), .STAMP_BITS(STAMP_BITS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd_action, .cmd_stamp, .cmd_object,
    .cmd_message, .cmd_outlet, .empty(empty_raw), .pop(pop && !empty), .status,
    .occupancy, .front_valid(fv), .front_stamp(fs), .front_object(fo),
    .front_message(fm), .front_outlet(fl)
  );

  // result shown once the store has settled after the update
  always_ff @(posedge clk) begin
    if (rst) hold <= 1'b0;
    else hold <= !empty_raw;
  end
  assign empty = empty_raw || !hold;
  assign front_valid   = fv;
  assign front_stamp   = fs;
  assign front_object  = fo;
  assign front_message = fm;
  assign front_outlet  = fl;
endmodule
`default_nettype wire

[rtl/tomq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module tomq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [1:0] status,
  input wire logic [6:0] occupancy,
  input wire logic       front_valid
);
  a_front: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (front_valid == (occupancy != 7'd0))) else $error("front flag");
  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status <= 2'(tomq_pkg::ST_MISS)) else $error("status code");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(occupancy)))
    else $error("result changed");
  a_reset: assert property (@(posedge clk)
    rst |=> (!full && empty)) else $error("reset state");
endmodule
bind timestamp_ordered_message_queue_top tomq_checker u_chk (
  .clk, .rst, .full, .empty, .pop, .status, .occupancy, .front_valid
);
`default_nettype wire
